// ===== sv/vefc_pkg.sv =====
// ----------------------------------------------------------------------------
// vefc_pkg: shared types and constants of the volume element format converter
// Holds the element type codes, the pixel format codes and the records of
// one element as it moves through the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package vefc_pkg;

  localparam logic [2:0] ET_U8      = 3'd0;
  localparam logic [2:0] ET_U16     = 3'd1;
  localparam logic [2:0] ET_S16     = 3'd2;
  localparam logic [2:0] ET_S32     = 3'd3;
  localparam logic [2:0] ET_F32     = 3'd4;
  localparam logic [2:0] ET_F64     = 3'd5;

  localparam logic [1:0] PF_G8      = 2'd0;
  localparam logic [1:0] PF_G16     = 2'd1;
  localparam logic [1:0] PF_R32F    = 2'd2;
  localparam logic [1:0] PF_OTHER   = 2'd3;

  localparam logic [15:0] S16_OFFSET = 16'h7FFF;

  // One element after decode: a normalized significand,
  // a binary32 biased exponent, and special handling flags.
  typedef struct packed {
    logic        sign;
    logic        is_float;    // goes through rounding
    logic        is_zero;     // signed zero result
    logic        is_inf;      // signed infinity result
    logic        is_nan;
    logic [21:0] nan_pay;
    logic signed [12:0] fe;   // binary32 biased exponent
    logic [52:0] sig;         // leading one at bit 52
    logic [31:0] raw;         // pass-through bits
    logic [1:0]  fmt;
    logic        last;
  } dec_t;

  // Element after alignment: 24-bit kept part plus guard and sticky.
  typedef struct packed {
    logic        sign;
    logic        is_float;
    logic        is_zero;
    logic        is_inf;
    logic        is_nan;
    logic [21:0] nan_pay;
    logic        normal;      // fe >= 1
    logic [7:0]  exp_m1;      // fe - 1 when normal
    logic [23:0] keep;
    logic        half;
    logic        sticky;
    logic [31:0] raw;
    logic [1:0]  fmt;
    logic        last;
  } aln_t;

endpackage
`default_nettype wire

// ===== sv/vefc_decode.sv =====
// ----------------------------------------------------------------------------
// vefc_decode: first stage, unpacks an element into sign, exponent, significand
// Signed 32-bit integers are normalized with a leading-zero count; binary64 is unpacked.
// ----------------------------------------------------------------------------
`default_nettype none
module vefc_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [2:0]       etype,
  input  wire logic [63:0]      bits,
  input  wire logic             last,
  output logic                  vld_r,
  output vefc_pkg::dec_t        dec_r
);

  vefc_pkg::dec_t dec_nxt;
  logic [31:0]    mag;
  logic [4:0]     lz;
  logic [31:0]    norm;
  logic [10:0]    ex;

  always_comb begin
    mag = bits[31] ? (~bits[31:0] + 32'd1) : bits[31:0];
    lz  = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 5'(31 - i);
    end
    norm = mag << lz;
    ex   = bits[62:52];
  end

  always_comb begin
    dec_nxt          = '0;
    dec_nxt.raw      = bits[31:0];
    dec_nxt.last     = last;
    case (etype)
      vefc_pkg::ET_U8: begin
        dec_nxt.raw = {24'd0, bits[7:0]};
        dec_nxt.fmt = vefc_pkg::PF_G8;
      end
      vefc_pkg::ET_U16: begin
        dec_nxt.raw = {16'd0, bits[15:0]};
        dec_nxt.fmt = vefc_pkg::PF_G16;
      end
      vefc_pkg::ET_S16: begin
        dec_nxt.raw = {16'd0, bits[15:0] + vefc_pkg::S16_OFFSET};
        dec_nxt.fmt = vefc_pkg::PF_G16;
      end
      vefc_pkg::ET_S32: begin
        dec_nxt.fmt      = vefc_pkg::PF_R32F;
        dec_nxt.is_float = 1'b1;
        dec_nxt.sign     = bits[31];
        dec_nxt.is_zero  = (mag == 32'd0);
        dec_nxt.sig      = {norm, 21'd0};
        dec_nxt.fe       = 13'(127 + 31) - 13'(lz);
      end
      vefc_pkg::ET_F32: begin
        dec_nxt.fmt = vefc_pkg::PF_R32F;
      end
      vefc_pkg::ET_F64: begin
        dec_nxt.fmt      = vefc_pkg::PF_R32F;
        dec_nxt.is_float = 1'b1;
        dec_nxt.sign     = bits[63];
        dec_nxt.sig      = {1'b1, bits[51:0]};
        dec_nxt.fe       = 13'(ex) - 13'sd896;
        // The top payload bit lands on the quiet bit, so only the next 22 are kept.
        dec_nxt.nan_pay  = bits[50:29];
        if (ex == 11'h7FF) begin
          dec_nxt.is_nan = (bits[51:0] != 52'd0);
          dec_nxt.is_inf = (bits[51:0] == 52'd0);
        end else if (ex == 11'd0) begin
          dec_nxt.is_zero = 1'b1;
        end else if (ex >= 11'd1151) begin
          dec_nxt.is_inf = 1'b1;
        end
      end
      default: begin
        dec_nxt.fmt = vefc_pkg::PF_OTHER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/vefc_align.sv =====
// ----------------------------------------------------------------------------
// vefc_align: second stage, shifts the significand to binary32 precision
// Produces the 24-bit kept part with the half and sticky bits for rounding.
// ----------------------------------------------------------------------------
`default_nettype none
module vefc_align (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire vefc_pkg::dec_t   dec,
  output logic                  vld_r,
  output vefc_pkg::aln_t        aln_r
);

  vefc_pkg::aln_t aln_nxt;
  logic [5:0]     extra;     // additional right shift beyond 29
  logic [82:0]    wide;      // sig with 30 guard positions below
  logic [82:0]    shifted;
  logic           tiny;

  always_comb begin
    // Total shift is 29 for normals and 30 - fe for subnormals; beyond 60
    // the value flushes to zero.
    tiny  = (dec.fe < -13'sd30);
    extra = (dec.fe >= 13'sd1) ? 6'd0 : 6'(13'sd1 - dec.fe);
    wide  = {dec.sig, 30'd0};
    shifted = wide >> extra;
    aln_nxt          = '0;
    aln_nxt.sign     = dec.sign;
    aln_nxt.is_float = dec.is_float;
    aln_nxt.is_zero  = dec.is_zero || (dec.is_float && !dec.is_inf && !dec.is_nan && tiny);
    aln_nxt.is_inf   = dec.is_inf;
    aln_nxt.is_nan   = dec.is_nan;
    aln_nxt.nan_pay  = dec.nan_pay;
    aln_nxt.normal   = (dec.fe >= 13'sd1);
    aln_nxt.exp_m1   = 8'(dec.fe - 13'sd1);
    aln_nxt.keep     = shifted[82:59];
    aln_nxt.half     = shifted[58];
    aln_nxt.sticky   = |shifted[57:0];
    aln_nxt.raw      = dec.raw;
    aln_nxt.fmt      = dec.fmt;
    aln_nxt.last     = dec.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      aln_r <= aln_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/vefc_round.sv =====
// ----------------------------------------------------------------------------
// vefc_round: third stage, rounds to nearest even and packs binary32
// Also selects the pass-through pixel for the u8, u16, s16, binary32 and unknown types.
// ----------------------------------------------------------------------------
`default_nettype none
module vefc_round (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire vefc_pkg::aln_t   aln,
  output logic                  vld_r,
  output logic [31:0]           pix_r,
  output logic [1:0]            fmt_r,
  output logic                  last_r
);

  logic [24:0] keep_rnd;
  logic [31:0] mag;
  logic [31:0] pix_nxt;

  always_comb begin
    keep_rnd = {1'b0, aln.keep} +
               25'(aln.half && (aln.sticky || aln.keep[0]));
    // Carry out of the significand rolls into the exponent by the add.
    mag = aln.normal ? ({1'b0, aln.exp_m1, 23'd0} + {7'd0, keep_rnd})
                     : {7'd0, keep_rnd};
    if (mag >= 32'h7F80_0000) mag = 32'h7F80_0000;
    if (!aln.is_float) begin
      pix_nxt = aln.raw;
    end else if (aln.is_nan) begin
      pix_nxt = {aln.sign, 9'h1FF, aln.nan_pay};
    end else if (aln.is_inf) begin
      pix_nxt = {aln.sign, 31'h7F80_0000};
    end else if (aln.is_zero) begin
      pix_nxt = {aln.sign, 31'd0};
    end else begin
      pix_nxt = {aln.sign, mag[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      pix_r  <= pix_nxt;
      fmt_r  <= aln.fmt;
      last_r <= aln.last;
    end
  end

endmodule
`default_nettype wire

// ===== sv/voxel_element_format_converter_core.sv =====
// ----------------------------------------------------------------------------
// voxel_element_format_converter_core: volume element to pixel converter
//
//   channel | ports                                   | direction
//   in      | in_valid, in_ready, in_element_bits, in_is_last | sink
//   out     | out_valid, out_ready, out_pixel_bits, out_pixel_format, out_last_out | source
//   cfg     | cfg_we, cfg_element_type                | sink, write only
//
// Three register stages: decode, alignment, rounding; a transaction passes
// them in order on its way to the output. One transaction is taken per cycle
// unless stalled; the pipeline advances as one unit when the output register
// is empty or being read. A stall freezes all stages. Reset clears the stage
// valid bits and sets the element type to u8.
// ----------------------------------------------------------------------------
`default_nettype none
module voxel_element_format_converter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_element_bits,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_pixel_bits,
  output logic [1:0]       out_pixel_format,
  output logic             out_last_out,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_element_type
);

  logic [2:0]     etype_r;
  logic           en;
  logic           d_vld, a_vld;
  vefc_pkg::dec_t dec;
  vefc_pkg::aln_t aln;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etype_r <= vefc_pkg::ET_U8;
    end else if (cfg_we) begin
      etype_r <= cfg_element_type;
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  vefc_decode u_dec (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .etype(etype_r), .bits(in_element_bits), .last(in_is_last),
    .vld_r(d_vld), .dec_r(dec)
  );

  vefc_align u_aln (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(d_vld),
    .dec(dec), .vld_r(a_vld), .aln_r(aln)
  );

  vefc_round u_rnd (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(a_vld), .aln(aln),
    .vld_r(out_valid), .pix_r(out_pixel_bits), .fmt_r(out_pixel_format),
    .last_r(out_last_out)
  );

  // A stalled result must stay put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_bits))
    else $error("result changed during stall");
  // Pipeline frozen when stalled.
  a_frz: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(d_vld) && $stable(a_vld))
    else $error("stage moved during stall");
  // G8 pixels leave the upper 24 bits clear.
  a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_format == vefc_pkg::PF_G8 |-> out_pixel_bits[31:8] == 24'd0)
    else $error("G8 pixel has upper bits");

endmodule
`default_nettype wire
